>>> hw/rtl/bwlt_pkg.sv
// Shared types, constants and helpers for the byte word and line tokenizer.
package bwlt_pkg;

  // Size of the text buffer in bytes; offsets saturate below it.
  localparam int unsigned BUFFER_BYTES = 65536;

  localparam int unsigned CNT_W   = 16;
  localparam int unsigned MASK_W  = 64;
  localparam int unsigned MASK_N  = 4;
  localparam int unsigned CFG_IDX_W = $clog2(MASK_N);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] POS_CAP = (BUFFER_BYTES - 1 < 65535) ?
                                         CNT_W'(BUFFER_BYTES - 1) : CNT_MAX;

  // Line ending characters.
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // Separator mask register indexes and their reset values.
  localparam logic [CFG_IDX_W-1:0] REG_SEP_MASK_0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_MASK_1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_MASK_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_MASK_3 = 2'd3;

  localparam logic [MASK_W-1:0] SEP_MASK_0_RST = 64'h2000_0001_FFFF_FFFF;
  localparam logic [MASK_W-1:0] SEP_MASK_1_RST = 64'h9000_0000_0000_0000;
  localparam logic [MASK_W-1:0] SEP_MASK_2_RST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [MASK_W-1:0] SEP_MASK_3_RST = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic             has_word;
    logic [CNT_W-1:0] word_start;
    logic [CNT_W-1:0] word_length;
    logic [CNT_W-1:0] line_number;
    logic [CNT_W-1:0] word_in_line;
    logic             closes_line;
    logic             buffer_done;
    logic [CNT_W-1:0] line_total;
  } out_item_t;

  // Increment, holding at the top value.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

>>> hw/rtl/bwlt_in_if.sv
// Valid/ready channel carrying input bytes.
interface bwlt_in_if;
  import bwlt_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/bwlt_out_if.sv
// Valid/ready channel carrying word records.
interface bwlt_out_if;
  import bwlt_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/byte_word_line_tokenizer.sv
// Top level of the byte word and line tokenizer.
//
// Takes one text byte per cycle and gives at most one word record per byte.
// Each accepted byte lands in an input register, is classified against the
// 256-bit separator mask and the offset/line counters, and its record (if
// any) goes to an output register; a new byte is taken every cycle as long
// as the output register is free or being drained. Bytes 10 and 13 end a
// line and always emit a record; a separator emits a record only when it
// closes a non-empty word; the byte flagged end_of_buffer always emits a
// record with the line count and resets the counters for the next buffer.
// Write the separator masks only while the block is idle.
module byte_word_line_tokenizer (
  input  logic                             clk,
  input  logic                             rst_n,
  bwlt_in_if.sink                          in_ch,
  bwlt_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [bwlt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [bwlt_pkg::MASK_W-1:0]      cfg_wdata
);
  import bwlt_pkg::*;

  logic [MASK_W-1:0] sep_mask_r [MASK_N];

  logic              in_vld_r;
  in_item_t          in_item_r;

  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  tok_r, tok_nxt;
  logic [CNT_W-1:0]  line_r, line_nxt;
  logic [CNT_W-1:0]  wil_r, wil_nxt;

  logic              out_vld_r;
  out_item_t         out_item_r;
  out_item_t         rec;

  logic              is_nl, is_sep, close_sep, emit, flush, produce, advance, last;
  logic [CNT_W-1:0]  pos_inc, tok_after, line_after, wil_after, word_end;
  logic [7:0]        b;

  // Separator mask registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_mask_r[REG_SEP_MASK_0] <= SEP_MASK_0_RST;
      sep_mask_r[REG_SEP_MASK_1] <= SEP_MASK_1_RST;
      sep_mask_r[REG_SEP_MASK_2] <= SEP_MASK_2_RST;
      sep_mask_r[REG_SEP_MASK_3] <= SEP_MASK_3_RST;
    end else if (cfg_we) begin
      sep_mask_r[cfg_idx] <= cfg_wdata;
    end
  end

  // Classify the held byte
  assign b      = in_item_r.text_byte;
  assign last   = in_item_r.end_of_buffer;
  assign is_nl  = (b == CHAR_LF) || (b == CHAR_CR);
  assign is_sep = !is_nl && sep_mask_r[b[7:6]][b[5:0]];

  assign pos_inc   = (pos_r < POS_CAP) ? pos_r + CNT_W'(1) : POS_CAP;
  assign close_sep = is_sep && (pos_r != tok_r);
  assign emit      = is_nl || close_sep;
  assign tok_after = (is_nl || is_sep) ? pos_inc : tok_r;
  assign line_after = is_nl ? sat_inc(line_r) : line_r;
  assign flush     = last && !emit && (pos_inc != tok_after);
  assign produce   = emit || last;
  assign word_end  = emit ? pos_r : pos_inc;

  always_comb begin
    if (is_nl) begin
      wil_after = '0;
    end else if (close_sep) begin
      wil_after = sat_inc(wil_r);
    end else begin
      wil_after = wil_r;
    end
  end

  // Build the record
  always_comb begin
    rec = '0;
    if (emit || flush) begin
      rec.has_word     = 1'b1;
      rec.word_start   = tok_r;
      rec.word_length  = word_end - tok_r;
      rec.line_number  = line_r;
      rec.word_in_line = wil_r;
      rec.closes_line  = is_nl;
    end
    rec.buffer_done = last;
    rec.line_total  = last ? sat_inc(line_after) : '0;
  end

  // Advance the held byte when its record has room
  assign advance      = in_vld_r && (!produce || !out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || advance;

  // Next counter state; the final byte clears everything
  always_comb begin
    pos_nxt  = pos_r;
    tok_nxt  = tok_r;
    line_nxt = line_r;
    wil_nxt  = wil_r;
    if (advance) begin
      if (last) begin
        pos_nxt  = '0;
        tok_nxt  = '0;
        line_nxt = '0;
        wil_nxt  = '0;
      end else begin
        pos_nxt  = pos_inc;
        tok_nxt  = tok_after;
        line_nxt = line_after;
        wil_nxt  = wil_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tok_r  <= '0;
      line_r <= '0;
      wil_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      tok_r  <= tok_nxt;
      line_r <= line_nxt;
      wil_r  <= wil_nxt;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= in_ch.data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && produce) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produce) begin
      out_item_r <= rec;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_item_r;

endmodule
